// File: src/mmt_pkg.sv
`default_nettype none

package mmt_pkg;

  localparam int unsigned DIM_DEFAULT = 6;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned IDX_IN_W  = 3;
  localparam int unsigned OUT_IDX_W = 3;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned VAL_W     = 41;

  localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  // control that travels with each partial dot product down the chain
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

// File: src/mmt_if.sv
`default_nettype none

interface mmt_in_if;
  import mmt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [IDX_IN_W-1:0]        row_index;
  logic [IDX_IN_W-1:0]        col_index;
  logic signed [ELEM_W-1:0]   element_value;

  modport source (output valid, mode, row_index, col_index, element_value, input ready);
  modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

interface mmt_out_if;
  import mmt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OUT_IDX_W-1:0]       out_row;
  logic [OUT_IDX_W-1:0]       out_col;
  logic signed [VAL_W-1:0]    out_value;
  logic                       is_total;
  logic                       last_result;

  modport source (output valid, out_row, out_col, out_value, is_total, last_result,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, is_total, last_result,
                  output ready);
endinterface

`default_nettype wire

// File: src/mmt_cell.sv
`default_nettype none

module mmt_cell #(
  parameter int unsigned MATRIX_DIM = mmt_pkg::DIM_DEFAULT,
  parameter int unsigned CELL_IDX   = 0,
  localparam int unsigned IDX_W     = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              ld_a_en,
  input  logic                              ld_b_en,
  input  logic [IDX_W-1:0]                  ld_row,
  input  logic [IDX_W-1:0]                  ld_col,
  input  logic signed [mmt_pkg::ELEM_W-1:0] ld_data,
  input  mmt_pkg::tag_t                     tag_i,
  input  logic [IDX_W-1:0]                  row_i,
  input  logic [IDX_W-1:0]                  col_i,
  input  logic signed [mmt_pkg::VAL_W-1:0]  sum_i,
  output mmt_pkg::tag_t                     tag_o,
  output logic [IDX_W-1:0]                  row_o,
  output logic [IDX_W-1:0]                  col_o,
  output logic signed [mmt_pkg::VAL_W-1:0]  sum_o
);
  import mmt_pkg::*;

  localparam logic [IDX_W-1:0] CELL_ID = IDX_W'(CELL_IDX);

  // column CELL_IDX of the first matrix, row CELL_IDX of the second
  logic signed [ELEM_W-1:0] a_mem_r [MATRIX_DIM];
  logic signed [ELEM_W-1:0] b_mem_r [MATRIX_DIM];

  tag_t                     tag_r;
  logic [IDX_W-1:0]         row_r;
  logic [IDX_W-1:0]         col_r;
  logic signed [VAL_W-1:0]  sum_r;

  logic signed [ELEM_W-1:0] a_rd;
  logic signed [ELEM_W-1:0] b_rd;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  sum_nxt;

  always_ff @(posedge clk) begin
    if (ld_a_en && ld_col == CELL_ID) begin
      a_mem_r[ld_row] <= ld_data;
    end
    if (ld_b_en && ld_row == CELL_ID) begin
      b_mem_r[ld_col] <= ld_data;
    end
  end

  always_comb begin
    a_rd    = a_mem_r[row_i];
    b_rd    = b_mem_r[col_i];
    prod    = a_rd * b_rd;
    sum_nxt = sum_i + {{(VAL_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (adv) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_r <= row_i;
      col_r <= col_i;
      sum_r <= sum_nxt;
    end
  end

  assign tag_o = tag_r;
  assign row_o = row_r;
  assign col_o = col_r;
  assign sum_o = sum_r;

endmodule

`default_nettype wire

// File: src/matrix_multiply_and_total.sv
// channel   dir  handshake      word
// in_ch     in   valid/ready    mode, row_index, col_index, element_value
// out_ch    out  valid/ready    out_row, out_col, out_value, is_total, last_result
//
// a load word keeps the block idle, so a new word is taken every cycle while idle
// a compute word occupies the block through RUN, DRAIN and TOTAL:
// one product entry enters the chain of N cells per cycle while out_ch is not
// stalled, and each cell adds one multiply to the running dot product
// out_ch stalls freeze the whole cell chain; in_ch is not ready during a compute
// rst_n is synchronous; the matrix stores are not cleared by reset
`default_nettype none

module matrix_multiply_and_total #(
  parameter int unsigned MATRIX_DIM = mmt_pkg::DIM_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  mmt_in_if.sink     in_ch,
  mmt_out_if.source  out_ch
);
  import mmt_pkg::*;

  localparam int unsigned IDX_W = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
  localparam int unsigned CW    = ($clog2(MATRIX_DIM + 1) > OUT_IDX_W) ?
                                  $clog2(MATRIX_DIM + 1) : OUT_IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_DIM - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_TOTAL = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic [IDX_W-1:0]        j_r, j_nxt;
  logic signed [VAL_W-1:0] total_r, total_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0]    out_row_r;
  logic [OUT_IDX_W-1:0]    out_col_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_flag_r;

  logic                    in_acc;
  logic [CW-1:0]           row_ext;
  logic [CW-1:0]           col_ext;
  logic                    in_range;
  logic                    ld_a_en;
  logic                    ld_b_en;
  logic                    start;
  logic                    adv;
  logic                    load_entry;
  logic                    load_total;
  logic [CW-1:0]           exit_row_ext;
  logic [CW-1:0]           exit_col_ext;

  tag_t                    ch_tag [MATRIX_DIM+1];
  logic [IDX_W-1:0]        ch_row [MATRIX_DIM+1];
  logic [IDX_W-1:0]        ch_col [MATRIX_DIM+1];
  logic signed [VAL_W-1:0] ch_sum [MATRIX_DIM+1];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign row_ext  = CW'(in_ch.row_index);
  assign col_ext  = CW'(in_ch.col_index);
  assign in_range = (row_ext < CW'(MATRIX_DIM)) && (col_ext < CW'(MATRIX_DIM));
  assign ld_a_en  = in_acc && in_range && (in_ch.mode == MODE_LOAD_A);
  assign ld_b_en  = in_acc && in_range && (in_ch.mode == MODE_LOAD_B);
  assign start    = in_acc && (in_ch.mode == MODE_COMPUTE);

  // chain moves whenever the output register can take a word
  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    ch_tag[0].valid = (state_r == ST_RUN);
    ch_tag[0].last  = (i_r == LAST_IDX) && (j_r == LAST_IDX);
    ch_row[0]       = i_r;
    ch_col[0]       = j_r;
    ch_sum[0]       = '0;
  end

  for (genvar k = 0; k < MATRIX_DIM; k++) begin : g_cell
    mmt_cell #(
      .MATRIX_DIM (MATRIX_DIM),
      .CELL_IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .ld_a_en (ld_a_en),
      .ld_b_en (ld_b_en),
      .ld_row  (row_ext[IDX_W-1:0]),
      .ld_col  (col_ext[IDX_W-1:0]),
      .ld_data (in_ch.element_value),
      .tag_i   (ch_tag[k]),
      .row_i   (ch_row[k]),
      .col_i   (ch_col[k]),
      .sum_i   (ch_sum[k]),
      .tag_o   (ch_tag[k+1]),
      .row_o   (ch_row[k+1]),
      .col_o   (ch_col[k+1]),
      .sum_o   (ch_sum[k+1])
    );
  end

  assign load_entry = adv && ch_tag[MATRIX_DIM].valid;
  assign load_total = adv && (state_r == ST_TOTAL);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    total_nxt = total_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          total_nxt = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (j_r == LAST_IDX) begin
            j_nxt = '0;
            if (i_r == LAST_IDX) begin
              state_nxt = ST_DRAIN;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (load_entry && ch_tag[MATRIX_DIM].last) begin
          state_nxt = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        if (adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load_entry) begin
      total_nxt = total_r + ch_sum[MATRIX_DIM];
    end
  end

  always_comb begin
    if (load_entry || load_total) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign exit_row_ext = CW'(ch_row[MATRIX_DIM]);
  assign exit_col_ext = CW'(ch_col[MATRIX_DIM]);

  always_ff @(posedge clk) begin
    if (load_entry) begin
      out_row_r   <= exit_row_ext[OUT_IDX_W-1:0];
      out_col_r   <= exit_col_ext[OUT_IDX_W-1:0];
      out_value_r <= ch_sum[MATRIX_DIM];
      out_flag_r  <= 1'b0;
    end else if (load_total) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= total_r;
      out_flag_r  <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_row     = out_row_r;
  assign out_ch.out_col     = out_col_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.is_total    = out_flag_r;
  assign out_ch.last_result = out_flag_r;

endmodule

`default_nettype wire

// File: src/mmt_checker.sv
`default_nettype none

module mmt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mmt_pkg::OUT_IDX_W-1:0]    out_row,
  input logic [mmt_pkg::OUT_IDX_W-1:0]    out_col,
  input logic signed [mmt_pkg::VAL_W-1:0] out_value,
  input logic                             is_total,
  input logic                             last_result
);
  import mmt_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row)
      && $stable(out_col) && $stable(is_total))
    else $error("result word changed while stalled");

  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_total == last_result)
    else $error("total and last flags disagree");

  a_total_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_total |-> out_row == '0 && out_col == '0)
    else $error("total word carries a nonzero position");

  // product entries only appear inside a compute run, when loads are held off
  a_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_total |-> !in_ready)
    else $error("input ready while product entries pending");

endmodule

bind matrix_multiply_and_total mmt_checker u_mmt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_row     (out_ch.out_row),
  .out_col     (out_ch.out_col),
  .out_value   (out_ch.out_value),
  .is_total    (out_ch.is_total),
  .last_result (out_ch.last_result)
);

`default_nettype wire

// File: dv/mmt_product_check.sv
`timescale 1ns / 100ps

module mmt_product_check
  import mmt_pkg::*;
#(
  parameter int unsigned DIM = DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  mmt_in_if           in_mon,
  mmt_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned words_pending
);

  typedef struct packed {
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic [VAL_W-1:0]     value;
    logic                 is_total;
    logic                 last;
  } product_word_t;

  logic signed [ELEM_W-1:0] first_mat  [DIM][DIM];
  logic signed [ELEM_W-1:0] second_mat [DIM][DIM];
  product_word_t            products_due [$];
  int unsigned              errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // every entry of first*second row by row, then the sum of all entries
  function automatic void predict_products();
    logic [VAL_W-1:0] total;
    logic [VAL_W-1:0] entry;
    longint           dot;
    total = '0;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        dot = 0;
        for (int k = 0; k < DIM; k++)
          dot += longint'(first_mat[i][k]) * longint'(second_mat[k][j]);
        entry = dot[VAL_W-1:0];
        total = total + entry;
        products_due.push_back('{OUT_IDX_W'(i), OUT_IDX_W'(j), entry, 1'b0, 1'b0});
      end
    end
    products_due.push_back('{'0, '0, total, 1'b1, 1'b1});
  endfunction

  always @(posedge clk) begin
    product_word_t got;
    product_word_t want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.out_row, out_mon.out_col, out_mon.out_value,
                out_mon.is_total, out_mon.last_result};
        if (products_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word row %0d col %0d value %0d",
                                    got.row, got.col, $signed(got.value)));
        end else begin
          want = products_due.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "got r%0d c%0d v%0d t%0b l%0b, want r%0d c%0d v%0d t%0b l%0b",
              got.row, got.col, $signed(got.value), got.is_total, got.last,
              want.row, want.col, $signed(want.value), want.is_total, want.last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.mode)
          MODE_LOAD_A, MODE_LOAD_B: begin
            // out of range indexes are dropped by the block
            if (in_mon.row_index < DIM && in_mon.col_index < DIM) begin
              if (in_mon.mode == MODE_LOAD_A)
                first_mat[in_mon.row_index][in_mon.col_index] = in_mon.element_value;
              else
                second_mat[in_mon.row_index][in_mon.col_index] = in_mon.element_value;
            end
          end
          MODE_COMPUTE: predict_products();
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    words_pending  <= products_due.size();
  end

endmodule

// File: dv/tb_matrix_multiply_and_total.sv
`timescale 1ns / 100ps

module tb_matrix_multiply_and_total;
  import mmt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned       DIM         = DIM_DEFAULT;
  localparam int unsigned       RAND_WORDS  = 60;
  localparam int unsigned       IDLE_LIMIT  = 3000;

  logic clk = 1'b0;
  logic rst_n;
  logic calm_in  = 1'b0;
  logic calm_out = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches;
  int unsigned pending;

  mmt_in_if  in_ch ();
  mmt_out_if out_ch ();

  matrix_multiply_and_total dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mmt_product_check #(.DIM(DIM)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatches),
    .words_pending  (pending)
  );

  always #4 clk = ~clk;

  // mostly short pauses, now and then a long one
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return ELEM_W'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [IDX_IN_W-1:0] r,
                           input logic [IDX_IN_W-1:0] c, input logic [ELEM_W-1:0] v);
    int unsigned gap;
    gap = (calm_in || $urandom_range(0, 1) != 0) ? 0 : pause_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= m;
    in_ch.row_index     <= r;
    in_ch.col_index     <= c;
    in_ch.element_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic load_all(input logic [MODE_W-1:0] m, input logic [ELEM_W-1:0] v);
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++)
        send_word(m, IDX_IN_W'(i), IDX_IN_W'(j), v);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm_out <= !calm_out;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm_out || $urandom_range(0, 2) != 0) begin
      out_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 6);
    end else begin
      out_ch.ready <= 1'b0;
      ready_hold   <= pause_len();
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned counted;
    int unsigned r;
    logic [MODE_W-1:0] m;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_LOAD_A;
    in_ch.row_index     = '0;
    in_ch.col_index     = '0;
    in_ch.element_value = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // most negative times most negative everywhere: largest entries and total
    load_all(MODE_LOAD_A, 16'h8000);
    load_all(MODE_LOAD_B, 16'h8000);
    send_word(MODE_COMPUTE, 3'd7, 3'd7, 16'hffff);
    // row 0 of the first matrix at the positive extreme: most negative entries
    for (int k = 0; k < DIM; k++)
      send_word(MODE_LOAD_A, 3'd0, IDX_IN_W'(k), 16'h7fff);
    // words that must leave the stores alone
    send_word(MODE_UNUSED, 3'd7, 3'd7, 16'hffff);
    send_word(MODE_UNUSED, 3'd0, 3'd0, 16'h0000);
    send_word(MODE_LOAD_A, 3'd6, 3'd0, 16'h1234);
    send_word(MODE_LOAD_B, 3'd0, 3'd7, 16'h5a5a);
    send_word(MODE_LOAD_A, 3'd7, 3'd7, 16'hffff);
    send_word(MODE_LOAD_B, 3'd5, 3'd6, 16'h0001);
    send_word(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_word(MODE_LOAD_B, 3'd5, 3'd5, 16'h0000);
    send_word(MODE_COMPUTE, 3'd5, 3'd2, 16'h7fff);

    counted = 0;
    while (counted < RAND_WORDS) begin
      if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        // whole fresh matrix with random content
        m = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
        for (int i = 0; i < DIM; i++)
          for (int j = 0; j < DIM; j++)
            send_word(m, IDX_IN_W'(i), IDX_IN_W'(j), rand_elem());
        counted += DIM * DIM;
      end else if (r < 8) begin
        send_word(MODE_COMPUTE, IDX_IN_W'($urandom_range(0, 7)),
                  IDX_IN_W'($urandom_range(0, 7)), rand_elem());
        counted++;
      end else if (r < 12) begin
        send_word(MODE_UNUSED, IDX_IN_W'($urandom_range(0, 7)),
                  IDX_IN_W'($urandom_range(0, 7)), rand_elem());
      end else if (r < 17) begin
        // at least one index past the edge
        m = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
        if ($urandom_range(0, 1))
          send_word(m, IDX_IN_W'($urandom_range(DIM, 7)),
                    IDX_IN_W'($urandom_range(0, 7)), rand_elem());
        else
          send_word(m, IDX_IN_W'($urandom_range(0, 7)),
                    IDX_IN_W'($urandom_range(DIM, 7)), rand_elem());
      end else begin
        m = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
        send_word(m, IDX_IN_W'($urandom_range(0, DIM - 1)),
                  IDX_IN_W'($urandom_range(0, DIM - 1)), rand_elem());
        counted++;
      end
    end
    send_word(MODE_COMPUTE, IDX_IN_W'($urandom_range(0, 7)),
              IDX_IN_W'($urandom_range(0, 7)), rand_elem());
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
